/* hdl/pcm_sample_player_mixer_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef PCM_SAMPLE_PLAYER_MIXER_UNIT_ASSERT_SVH
`define PCM_SAMPLE_PLAYER_MIXER_UNIT_ASSERT_SVH
// Consequent must hold in the cycle after the antecedent.
`define PSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define PSPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`endif

/* hdl/pspm_pkg.sv */
// ----------------------------------------------------------------------------
// pspm_pkg
// Types and constants shared by the PCM sample player mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package pspm_pkg;
    localparam int CHANNELS = 4;
    localparam int CH_W = 2;
    localparam int MEM_AW = 16;
    localparam int MEM_BYTES = 65536;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_MEM = 2'd1;
    localparam logic [1:0] FUNC_SET = 2'd2;

    localparam logic [3:0] SET_START = 4'd0;
    localparam logic [3:0] SET_END = 4'd1;
    localparam logic [3:0] SET_LBEG = 4'd2;
    localparam logic [3:0] SET_LEND = 4'd3;
    localparam logic [3:0] SET_FREQ = 4'd4;
    localparam logic [3:0] SET_VOL = 4'd5;
    localparam logic [3:0] SET_EN = 4'd6;
    localparam logic [3:0] SET_LOOP = 4'd7;
    localparam logic [3:0] SET_WIDE = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_MEM,
        CMD_SET
    } cmd_kind_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  chan;
        logic [3:0]  setting;
        logic [15:0] value;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_PHASE,
        ST_RD0,
        ST_RD1,
        ST_WAIT,
        ST_GET,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } back_state_t;
endpackage
`default_nettype wire

/* hdl/pspm_ram.sv */
// ----------------------------------------------------------------------------
// pspm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read in the same cycle as a write returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* hdl/pspm_front.sv */
// ----------------------------------------------------------------------------
// pspm_front
// Classifies input requests and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
module pspm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       func,
    input  wire logic [15:0]      mem_addr,
    input  wire logic [7:0]       mem_byte,
    input  wire logic [1:0]       chan,
    input  wire logic [3:0]       setting,
    input  wire logic [15:0]      setting_value,
    output logic                  q_valid,
    input  wire logic             q_pop,
    output pspm_pkg::cmd_t        q_cmd
);
    import pspm_pkg::*;

    cmd_t       q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, keep;
    cmd_t       cmd;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_ptr_reg];

    // Classify: unused func codes are dropped here.
    always_comb
    begin
        cmd.addr    = mem_addr;
        cmd.data    = mem_byte;
        cmd.chan    = chan;
        cmd.setting = setting;
        cmd.value   = setting_value;
        keep        = 1'b1;
        unique case (func)
            FUNC_TICK: cmd.kind = CMD_TICK;
            FUNC_MEM:  cmd.kind = CMD_MEM;
            FUNC_SET:  cmd.kind = CMD_SET;
            default:
            begin
                cmd.kind = CMD_TICK;
                keep     = 1'b0;
            end
        endcase
    end

    assign push        = in_valid && in_ready && keep;
    assign wr_ptr_next = wr_ptr_reg ^ push;
    assign rd_ptr_next = rd_ptr_reg ^ q_pop;
    assign cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule
`default_nettype wire

/* hdl/pspm_back.sv */
// ----------------------------------------------------------------------------
// pspm_back
// Executes queued requests: memory writes, settings, and channel ticks.
// ----------------------------------------------------------------------------
`default_nettype none
module pspm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire pspm_pkg::cmd_t   q_cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [15:0]           sample_out,
    output logic [3:0]            active_mask
);
    import pspm_pkg::*;

    logic [15:0] base_reg;
    logic [15:0] start_reg [CHANNELS];
    logic [15:0] end_reg [CHANNELS];
    logic [15:0] lbeg_reg [CHANNELS];
    logic [15:0] lend_reg [CHANNELS];
    logic [15:0] rate_reg [CHANNELS];
    logic [6:0]  gain_reg [CHANNELS];
    logic [16:0] pos_reg [CHANNELS];
    logic [16:0] phase_reg [CHANNELS];
    logic [15:0] held_reg [CHANNELS];
    logic        en_reg [CHANNELS];
    logic        prior_reg [CHANNELS];
    logic        loop_reg [CHANNELS];
    logic        wide_reg [CHANNELS];

    back_state_t state_reg, state_next;
    logic [CH_W-1:0] ch_reg;
    logic [16:0] sum_reg;
    logic signed [22:0] prod_reg;
    logic signed [16:0] quot_reg;
    logic [7:0]  lo_reg;
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic [3:0]  mask_reg;

    logic        ram_we;
    logic [15:0] ram_addr;
    logic [7:0]  ram_rdata;
    logic [16:0] fetch_addr;

    pspm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_cmd.data),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign sample_out  = out_sample_reg;
    assign active_mask = mask_reg;

    assign fetch_addr = 17'(base_reg) + pos_reg[ch_reg];
    assign ram_we = (state_reg == ST_IDLE) && q_valid && (q_cmd.kind == CMD_MEM);

    // Memory address select. The second byte address is held through the wait
    // state so that its data is ready when the sample is assembled.
    always_comb
    begin
        if (state_reg == ST_RD1 || state_reg == ST_WAIT)
        begin
            ram_addr = fetch_addr[15:0] + 16'd1;
        end
        else if (state_reg == ST_RD0)
        begin
            ram_addr = fetch_addr[15:0];
        end
        else
        begin
            ram_addr = q_cmd.addr;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == CMD_TICK)
                    begin
                        if (!out_valid_reg)
                        begin
                            state_next = ST_EDGE;
                        end
                    end
                    else
                    begin
                        q_pop = 1'b1;
                    end
                end
            end
            ST_EDGE:  state_next = ST_PHASE;
            ST_PHASE:
            begin
                if (en_reg[ch_reg] && phase_reg[ch_reg][16] && (pos_reg[ch_reg] < 17'(end_reg[ch_reg])))
                begin
                    state_next = ST_RD0;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_GET;
            ST_GET:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (ch_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
                q_pop      = 1'b1;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Channel state, settings and mixing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            ch_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_sample_reg <= '0;
            mask_reg      <= '0;
            prod_reg      <= '0;
            quot_reg      <= '0;
            lo_reg        <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                start_reg[c] <= '0;
                end_reg[c]   <= '0;
                lbeg_reg[c]  <= '0;
                lend_reg[c]  <= '0;
                rate_reg[c]  <= '0;
                gain_reg[c]  <= '0;
                pos_reg[c]   <= '0;
                phase_reg[c] <= '0;
                held_reg[c]  <= '0;
                en_reg[c]    <= 1'b0;
                prior_reg[c] <= 1'b0;
                loop_reg[c]  <= 1'b0;
                wide_reg[c]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg  <= '0;
                    sum_reg <= '0;
                    if (q_valid && q_cmd.kind == CMD_SET)
                    begin
                        case (q_cmd.setting)
                            SET_START: start_reg[q_cmd.chan] <= q_cmd.value;
                            SET_END:   end_reg[q_cmd.chan] <= q_cmd.value;
                            SET_LBEG:  lbeg_reg[q_cmd.chan] <= q_cmd.value;
                            SET_LEND:  lend_reg[q_cmd.chan] <= q_cmd.value;
                            SET_FREQ:  rate_reg[q_cmd.chan] <= q_cmd.value;
                            SET_VOL:   gain_reg[q_cmd.chan] <= q_cmd.value[6:0];
                            SET_EN:    en_reg[q_cmd.chan] <= q_cmd.value[0];
                            SET_LOOP:  loop_reg[q_cmd.chan] <= q_cmd.value[0];
                            SET_WIDE:  wide_reg[q_cmd.chan] <= q_cmd.value[0];
                            default:   ;
                        endcase
                    end
                end
                // Enable edges, then phase step.
                ST_EDGE:
                begin
                    if (en_reg[ch_reg] && !prior_reg[ch_reg])
                    begin
                        pos_reg[ch_reg] <= 17'(start_reg[ch_reg]);
                    end
                    else if (!en_reg[ch_reg] && prior_reg[ch_reg])
                    begin
                        pos_reg[ch_reg] <= 17'(end_reg[ch_reg]);
                    end
                    if (en_reg[ch_reg])
                    begin
                        phase_reg[ch_reg] <= phase_reg[ch_reg] + 17'(rate_reg[ch_reg]);
                    end
                    else
                    begin
                        held_reg[ch_reg] <= '0;
                    end
                end
                ST_PHASE:
                begin
                    if (en_reg[ch_reg] && phase_reg[ch_reg][16])
                    begin
                        phase_reg[ch_reg][16] <= 1'b0;
                        if (pos_reg[ch_reg] >= 17'(end_reg[ch_reg]))
                        begin
                            en_reg[ch_reg]   <= 1'b0;
                            held_reg[ch_reg] <= '0;
                        end
                    end
                    prior_reg[ch_reg] <= en_reg[ch_reg] && !(phase_reg[ch_reg][16]
                        && (pos_reg[ch_reg] >= 17'(end_reg[ch_reg])));
                end
                // The first byte arrives in the cycle after its address.
                ST_RD1: lo_reg <= ram_rdata;
                // Assemble sample and advance position.
                ST_GET:
                begin
                    logic [16:0] np;
                    if (wide_reg[ch_reg])
                    begin
                        held_reg[ch_reg] <= {ram_rdata, lo_reg};
                        np = pos_reg[ch_reg] + 17'd2;
                    end
                    else
                    begin
                        held_reg[ch_reg] <= {lo_reg, 8'd0};
                        np = pos_reg[ch_reg] + 17'd1;
                    end
                    if (loop_reg[ch_reg] && np >= 17'(lend_reg[ch_reg]))
                    begin
                        np = 17'(lbeg_reg[ch_reg]);
                    end
                    pos_reg[ch_reg] <= np;
                end
                ST_MUL:
                begin
                    prod_reg <= $signed(held_reg[ch_reg]) * $signed({1'b0, gain_reg[ch_reg]});
                end
                // Truncating division by 127 on the magnitude.
                ST_DIV:
                begin
                    logic [21:0] mag;
                    logic [37:0] qm;
                    logic [15:0] q;
                    mag = prod_reg[22] ? 22'(-prod_reg) : 22'(prod_reg);
                    qm  = 38'(mag) * 38'd16513;
                    q   = qm[36:21];
                    if (22'(q) * 22'd127 + 22'd127 <= mag)
                    begin
                        q = q + 16'd1;
                    end
                    sum_reg <= sum_reg + (prod_reg[22] ? -17'(q) : 17'(q));
                    ch_reg  <= ch_reg + 1'b1;
                end
                ST_OUT:
                begin
                    out_valid_reg  <= 1'b1;
                    out_sample_reg <= sum_reg[16:1];
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        mask_reg[c] <= en_reg[c];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/pcm_sample_player_mixer_unit.sv */
// ----------------------------------------------------------------------------
// pcm_sample_player_mixer_unit
// Four-channel PCM player and mixer with a local 64 KiB sample memory.
// ----------------------------------------------------------------------------
// Channel   | Direction | Contents
// s_axis    | in        | tuser: func; tdata: mem_addr, mem_byte, chan, setting, setting_value
// m_axis    | out       | tdata: sample_out, active_mask
// cfg       | in        | sample_base, written on cfg_we
// Memory writes and settings are carried out by the back end as they are popped.
// A tick walks the channels in turn through the edge, phase, multiply and divide steps,
// with the read, wait and assemble steps before multiply when a sample is fetched; then output.
// A tick waits in the queue while the previous result is not yet taken.
// A two-entry queue lets requests be taken while the back end works.
// Reset clears all channel state; memory content is undefined until written.
`default_nettype none
module pcm_sample_player_mixer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // func[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // mem_addr[15:0], mem_byte[23:16], chan[25:24], setting[29:26],
    // setting_value[45:30], zero fill above
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sample_out[15:0], active_mask[19:16], zero fill above
    output logic [23:0]      m_axis_tdata
);
    import pspm_pkg::*;

    logic        q_valid, q_pop;
    cmd_t        q_cmd;
    logic [15:0] sample_out;
    logic [3:0]  active_mask;

    pspm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .func          (s_axis_tuser),
        .mem_addr      (s_axis_tdata[15:0]),
        .mem_byte      (s_axis_tdata[23:16]),
        .chan          (s_axis_tdata[25:24]),
        .setting       (s_axis_tdata[29:26]),
        .setting_value (s_axis_tdata[45:30]),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd)
    );

    pspm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .sample_out  (sample_out),
        .active_mask (active_mask)
    );

    assign m_axis_tdata = {4'd0, active_mask, sample_out};
endmodule
`default_nettype wire

/* hdl/pspm_checker.sv */
// ----------------------------------------------------------------------------
// pspm_checker
// Port-level checks for the PCM sample player mixer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pcm_sample_player_mixer_unit_assert.svh"
module pspm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    // A stalled result holds.
    `PSPM_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // The fill bits stay zero.
    `PSPM_ASSERT_NOW(a_fill, clk, rst_n, m_axis_tvalid, m_axis_tdata[23:20] == 4'd0)
    // A delivered result is not followed at once by another.
    `PSPM_ASSERT_NEXT(a_gap, clk, rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind pcm_sample_player_mixer_unit pspm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
